/* hdl/asp_pkg.sv */
// shared types and constants for the atlas shelf packer
// no dependencies; used by every module of the block

package asp_pkg;

    localparam int MIN_ATLAS_WIDTH_DEF = 256;
    localparam int MAX_ATLAS_SIZE_DEF  = 1024;
    localparam int NUM_PACKERS         = 3;

    localparam int DIM_W    = 11;   // item width / height, x cursor and row height
    localparam int POS_W    = 10;   // reported x position
    localparam int YPOS_W   = 16;   // y cursor and reported y position
    localparam int USED_W   = 17;   // y cursor plus row height
    localparam int CALC_W   = 16;   // atlas width / height arithmetic
    localparam int CW_W     = 12;   // chosen width field
    localparam int AH_W     = 13;   // atlas height field

    localparam int MIN_ATLAS_HEIGHT = 64;

    localparam logic [DIM_W-1:0]  XCUR_MAX = '1;
    localparam logic [YPOS_W-1:0] YCUR_MAX = '1;

    // placement of the current word in one packer
    typedef struct packed {
        logic [POS_W-1:0]  x_pos;
        logic [YPOS_W-1:0] y_pos;
        logic [USED_W-1:0] used;
    } lane_res_t;

    // atlas size decision for a finished batch
    typedef struct packed {
        logic [CW_W-1:0] chosen_width;
        logic [AH_W-1:0] atlas_height;
        logic            too_tall;
    } size_res_t;

endpackage

/* hdl/asp_shelf_lane.sv */
// one shelf packer: x / y cursor and row height for a single atlas width
// depends on asp_pkg

module asp_shelf_lane #(
    parameter int PACK_WIDTH = asp_pkg::MIN_ATLAS_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      clear,
    input  logic [asp_pkg::DIM_W-1:0] item_width,
    input  logic [asp_pkg::DIM_W-1:0] item_height,
    output asp_pkg::lane_res_t        res
);

    localparam int PW_W  = $clog2(PACK_WIDTH) + 1;
    localparam int CMP_W = (PW_W > asp_pkg::DIM_W + 1) ? PW_W : asp_pkg::DIM_W + 1;

    logic [asp_pkg::DIM_W-1:0]  x_cursor_reg, x_cursor_next;
    logic [asp_pkg::YPOS_W-1:0] y_cursor_reg, y_cursor_next;
    logic [asp_pkg::DIM_W-1:0]  row_height_reg, row_height_next;

    logic [CMP_W-1:0]            fit_sum;
    logic                        row_break;
    logic [asp_pkg::USED_W-1:0]  y_sum;
    logic [asp_pkg::DIM_W-1:0]   x_place;
    logic [asp_pkg::YPOS_W-1:0]  y_place;
    logic [asp_pkg::DIM_W-1:0]   row_base;
    logic [asp_pkg::DIM_W:0]     x_sum;
    logic [asp_pkg::DIM_W-1:0]   x_after;
    logic [asp_pkg::DIM_W-1:0]   row_after;

    always_comb
    begin
        fit_sum   = CMP_W'({1'b0, item_width} + {1'b0, x_cursor_reg});
        row_break = fit_sum > CMP_W'(PACK_WIDTH);
        y_sum     = asp_pkg::USED_W'(y_cursor_reg) + asp_pkg::USED_W'(row_height_reg)
                  + asp_pkg::USED_W'(1);

        // a row break opens a fresh row one pixel below the current one
        if (row_break)
        begin
            x_place  = '0;
            y_place  = (y_sum > asp_pkg::USED_W'(asp_pkg::YCUR_MAX)) ?
                       asp_pkg::YCUR_MAX : y_sum[asp_pkg::YPOS_W-1:0];
            row_base = '0;
        end
        else
        begin
            x_place  = x_cursor_reg;
            y_place  = y_cursor_reg;
            row_base = row_height_reg;
        end

        x_sum     = {1'b0, x_place} + {1'b0, item_width} + (asp_pkg::DIM_W+1)'(1);
        x_after   = (x_sum > (asp_pkg::DIM_W+1)'(asp_pkg::XCUR_MAX)) ?
                    asp_pkg::XCUR_MAX : x_sum[asp_pkg::DIM_W-1:0];
        row_after = (item_height > row_base) ? item_height : row_base;

        res.x_pos = x_place[asp_pkg::POS_W-1:0];
        res.y_pos = y_place;
        res.used  = asp_pkg::USED_W'(y_place) + asp_pkg::USED_W'(row_after);
    end

    always_comb
    begin
        x_cursor_next   = x_cursor_reg;
        y_cursor_next   = y_cursor_reg;
        row_height_next = row_height_reg;
        if (advance)
        begin
            if (clear)
            begin
                x_cursor_next   = '0;
                y_cursor_next   = '0;
                row_height_next = '0;
            end
            else
            begin
                x_cursor_next   = x_after;
                y_cursor_next   = y_place;
                row_height_next = row_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_cursor_reg   <= '0;
            y_cursor_reg   <= '0;
            row_height_reg <= '0;
        end
        else
        begin
            x_cursor_reg   <= x_cursor_next;
            y_cursor_reg   <= y_cursor_next;
            row_height_reg <= row_height_next;
        end
    end

endmodule

/* hdl/asp_size_select.sv */
// atlas size choice from the used height of each shelf packer
// depends on asp_pkg

module asp_size_select #(
    parameter int MIN_ATLAS_WIDTH = asp_pkg::MIN_ATLAS_WIDTH_DEF,
    parameter int MAX_ATLAS_SIZE  = asp_pkg::MAX_ATLAS_SIZE_DEF
) (
    input  logic [asp_pkg::USED_W-1:0] used [asp_pkg::NUM_PACKERS],
    output asp_pkg::size_res_t         res
);

    localparam int HEIGHT_CAP = MAX_ATLAS_SIZE * 4;
    localparam int HT_W       = $clog2(HEIGHT_CAP) + 1;
    localparam int HMIN_B     = $clog2(asp_pkg::MIN_ATLAS_HEIGHT);

    // clamp, then round up to a power of two no smaller than the minimum
    function automatic logic [asp_pkg::CALC_W-1:0] round_height(
        input logic [asp_pkg::USED_W-1:0] u
    );
        logic [asp_pkg::USED_W-1:0] capped;
        logic [asp_pkg::CALC_W-1:0] h;
        capped = (u > asp_pkg::USED_W'(HEIGHT_CAP)) ? asp_pkg::USED_W'(HEIGHT_CAP) : u;
        h      = asp_pkg::CALC_W'(asp_pkg::MIN_ATLAS_HEIGHT);
        for (int b = HT_W - 1; b >= HMIN_B; b--)
        begin
            if (asp_pkg::USED_W'(1 << b) >= capped)
                h = asp_pkg::CALC_W'(1 << b);
        end
        return h;
    endfunction

    logic [asp_pkg::CALC_W-1:0] heights [asp_pkg::NUM_PACKERS];
    logic [asp_pkg::CALC_W-1:0] pw;
    logic [asp_pkg::CALC_W-1:0] ch;
    logic [asp_pkg::CALC_W-1:0] cw;
    logic                       found;
    logic                       stop;

    always_comb
    begin
        for (int k = 0; k < asp_pkg::NUM_PACKERS; k++)
            heights[k] = round_height(used[k]);
    end

    // narrow to wide; widths above the size limit are never tried
    always_comb
    begin
        cw    = asp_pkg::CALC_W'(MIN_ATLAS_WIDTH);
        ch    = asp_pkg::CALC_W'(asp_pkg::MIN_ATLAS_HEIGHT);
        found = 1'b0;
        stop  = 1'b0;
        pw    = '0;
        for (int k = 0; k < asp_pkg::NUM_PACKERS; k++)
        begin
            pw = asp_pkg::CALC_W'(MIN_ATLAS_WIDTH) << k;
            if (!found && !stop)
            begin
                if (pw > asp_pkg::CALC_W'(MAX_ATLAS_SIZE))
                    stop = 1'b1;
                else
                begin
                    ch = heights[k];
                    if (ch <= pw)
                    begin
                        found = 1'b1;
                        cw    = pw;
                    end
                    else
                        cw = pw << 1;
                end
            end
        end

        res.chosen_width = cw[asp_pkg::CW_W-1:0];
        res.atlas_height = ch[asp_pkg::AH_W-1:0];
        res.too_tall     = ch > asp_pkg::CALC_W'(MAX_ATLAS_SIZE);
    end

endmodule

/* hdl/atlas_shelf_packer_top.sv */
// atlas shelf packer top level: input register, three shelf packers, size select, result register
// path: an accepted word is held in the input register, then moves into the result register when that is free
// throughput: one word per cycle while out_ready holds; a stalled result word holds back the input register
// reset: rst_n asynchronous active low; clears both stage valids and all packer cursors
// depends on asp_pkg, asp_shelf_lane, asp_size_select

module atlas_shelf_packer_top #(
    parameter int MIN_ATLAS_WIDTH = asp_pkg::MIN_ATLAS_WIDTH_DEF,
    parameter int MAX_ATLAS_SIZE  = asp_pkg::MAX_ATLAS_SIZE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,

    // input channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [asp_pkg::DIM_W-1:0]  item_width,
    input  logic [asp_pkg::DIM_W-1:0]  item_height,
    input  logic                       final_item,

    // result channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [asp_pkg::POS_W-1:0]  x_narrow,
    output logic [asp_pkg::YPOS_W-1:0] y_narrow,
    output logic [asp_pkg::POS_W-1:0]  x_medium,
    output logic [asp_pkg::YPOS_W-1:0] y_medium,
    output logic [asp_pkg::POS_W-1:0]  x_wide,
    output logic [asp_pkg::YPOS_W-1:0] y_wide,
    output logic                       batch_done,
    output logic [asp_pkg::CW_W-1:0]   chosen_width,
    output logic [asp_pkg::AH_W-1:0]   atlas_height,
    output logic                       too_tall
);

    // ------------------------------------------------------------------
    // input register: holds one word; refills in the same cycle it drains
    // ------------------------------------------------------------------
    logic                      in_valid_reg, in_valid_next;
    logic [asp_pkg::DIM_W-1:0] width_reg;
    logic [asp_pkg::DIM_W-1:0] height_reg;
    logic                      last_reg;

    // result register valid
    logic                      out_valid_reg, out_valid_next;

    // the held word moves into the result register when that register
    // is empty or its word is being taken this cycle
    logic                      advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            width_reg  <= item_width;
            height_reg <= item_height;
            last_reg   <= final_item;
        end
    end

    // ------------------------------------------------------------------
    // shelf packers, one per atlas width (min, 2x min, 4x min)
    // cursors update as the word advances; the last word of a batch clears them
    // ------------------------------------------------------------------
    asp_pkg::lane_res_t         lane_res [asp_pkg::NUM_PACKERS];
    logic [asp_pkg::USED_W-1:0] lane_used [asp_pkg::NUM_PACKERS];

    for (genvar k = 0; k < asp_pkg::NUM_PACKERS; k++)
    begin : g_lane
        asp_shelf_lane #(
            .PACK_WIDTH (MIN_ATLAS_WIDTH << k)
        ) u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .clear       (last_reg),
            .item_width  (width_reg),
            .item_height (height_reg),
            .res         (lane_res[k])
        );

        assign lane_used[k] = lane_res[k].used;
    end

    // ------------------------------------------------------------------
    // atlas size choice, looked at only for the last word of a batch
    // ------------------------------------------------------------------
    asp_pkg::size_res_t size_res;

    asp_size_select #(
        .MIN_ATLAS_WIDTH (MIN_ATLAS_WIDTH),
        .MAX_ATLAS_SIZE  (MAX_ATLAS_SIZE)
    ) u_size (
        .used (lane_used),
        .res  (size_res)
    );

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic [asp_pkg::POS_W-1:0]  x_narrow_reg;
    logic [asp_pkg::YPOS_W-1:0] y_narrow_reg;
    logic [asp_pkg::POS_W-1:0]  x_medium_reg;
    logic [asp_pkg::YPOS_W-1:0] y_medium_reg;
    logic [asp_pkg::POS_W-1:0]  x_wide_reg;
    logic [asp_pkg::YPOS_W-1:0] y_wide_reg;
    logic                       batch_done_reg;
    logic [asp_pkg::CW_W-1:0]   chosen_width_reg;
    logic [asp_pkg::AH_W-1:0]   atlas_height_reg;
    logic                       too_tall_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_narrow_reg     <= lane_res[0].x_pos;
            y_narrow_reg     <= lane_res[0].y_pos;
            x_medium_reg     <= lane_res[1].x_pos;
            y_medium_reg     <= lane_res[1].y_pos;
            x_wide_reg       <= lane_res[2].x_pos;
            y_wide_reg       <= lane_res[2].y_pos;
            batch_done_reg   <= last_reg;
            // size fields read zero except on the word that ends a batch
            chosen_width_reg <= last_reg ? size_res.chosen_width : '0;
            atlas_height_reg <= last_reg ? size_res.atlas_height : '0;
            too_tall_reg     <= last_reg && size_res.too_tall;
        end
    end

    assign out_valid    = out_valid_reg;
    assign x_narrow     = x_narrow_reg;
    assign y_narrow     = y_narrow_reg;
    assign x_medium     = x_medium_reg;
    assign y_medium     = y_medium_reg;
    assign x_wide       = x_wide_reg;
    assign y_wide       = y_wide_reg;
    assign batch_done   = batch_done_reg;
    assign chosen_width = chosen_width_reg;
    assign atlas_height = atlas_height_reg;
    assign too_tall     = too_tall_reg;

endmodule

/* hdl/asp_checker.sv */
// port-level checks for the atlas shelf packer, bound to the top level
// depends on asp_pkg and atlas_shelf_packer_top

module asp_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [asp_pkg::DIM_W-1:0]  item_width,
    input logic [asp_pkg::DIM_W-1:0]  item_height,
    input logic                       final_item,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [asp_pkg::POS_W-1:0]  x_narrow,
    input logic [asp_pkg::YPOS_W-1:0] y_narrow,
    input logic [asp_pkg::POS_W-1:0]  x_medium,
    input logic [asp_pkg::YPOS_W-1:0] y_medium,
    input logic [asp_pkg::POS_W-1:0]  x_wide,
    input logic [asp_pkg::YPOS_W-1:0] y_wide,
    input logic                       batch_done,
    input logic [asp_pkg::CW_W-1:0]   chosen_width,
    input logic [asp_pkg::AH_W-1:0]   atlas_height,
    input logic                       too_tall
);

    // an offered input word holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(item_width) && $stable(item_height)
            && $stable(final_item))
        else $error("input word changed while waiting");

    // a stalled result word holds (atlas_height and too_tall are not checked)
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_narrow) && $stable(y_narrow)
            && $stable(x_medium) && $stable(y_medium) && $stable(x_wide)
            && $stable(y_wide) && $stable(batch_done) && $stable(chosen_width))
        else $error("result word changed while stalled");

    // size fields only on the word that ends a batch
    a_size_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !batch_done |-> chosen_width == '0 && atlas_height == '0 && !too_tall)
        else $error("size fields set outside batch end");

    // atlas height is a power of two or zero
    a_height_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && batch_done |-> $onehot0(atlas_height))
        else $error("atlas height not a power of two");

    // a fitting atlas is never taller than it is wide
    a_height_fits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && batch_done && !too_tall |->
            atlas_height <= asp_pkg::AH_W'(chosen_width))
        else $error("atlas height exceeds chosen width");

endmodule

bind atlas_shelf_packer_top asp_checker u_asp_checker (.*);
